### design/gcd_pkg.sv
package gcd_pkg;

    typedef logic [63:0]        t_q;
    typedef logic [27:0]        t_unit;
    typedef logic [9:0]         t_den;
    typedef logic signed [27:0] t_lat;
    typedef logic signed [28:0] t_lon;

    // partial products of one 64x64 multiply
    typedef struct packed {
        logic [63:0] p00;
        logic [63:0] p01;
        logic [63:0] p10;
        logic [63:0] p11;
    } t_pp;

    // sideband that travels with an arcsine candidate
    typedef struct packed {
        logic swap;
        t_q   s;
    } t_side;

    localparam t_q   Q_ONE        = 64'h1000_0000_0000_0000;
    localparam t_q   PI_Q60       = 64'h3243_F6A8_885A_308D;
    localparam t_q   HALF_PI      = PI_Q60 >> 1;
    localparam t_q   RAD_PER_UNIT = PI_Q60 / 64'd360000000;
    localparam t_q   TWO_DIAM_M   = 64'd25484000;
    localparam t_lat LAT_LIM      = 28'sd90000000;
    localparam t_lon LON_LIM      = 29'sd180000000;
    localparam logic [28:0] QUARTER_UNITS = 29'd180000000;
    localparam logic [28:0] HALF_UNITS    = 29'd360000000;

    localparam int SIN_TERMS  = 12;
    localparam int SQRT_STEPS = 61;
    localparam int ASIN_STEPS = 60;
    localparam int TERM_LAT   = 6;
    localparam int SIN_LAT    = 2 + SIN_TERMS * TERM_LAT + 2;
    localparam int SQRT_LAT   = 2 * SQRT_STEPS;
    localparam int ASIN_LAT   = ASIN_STEPS * (1 + SIN_LAT) + 1;

    function automatic t_pp mul_pp(input t_q a, input t_q b);
        t_pp r;
        r.p00 = 64'(a[31:0])  * 64'(b[31:0]);
        r.p01 = 64'(a[31:0])  * 64'(b[63:32]);
        r.p10 = 64'(a[63:32]) * 64'(b[31:0]);
        r.p11 = 64'(a[63:32]) * 64'(b[63:32]);
        return r;
    endfunction

    function automatic logic [127:0] prod_of(input t_pp p);
        return {p.p11, 64'd0} + {32'd0, p.p01, 32'd0} + {32'd0, p.p10, 32'd0}
             + {64'd0, p.p00};
    endfunction

    // Q60 product: bits 123..60 of the full product
    function automatic t_q mulq_of(input t_pp p);
        logic [127:0] w;
        w = prod_of(p);
        return w[123:60];
    endfunction

    function automatic t_q mulhi_of(input t_pp p);
        logic [127:0] w;
        w = prod_of(p);
        return w[127:64];
    endfunction

endpackage

### design/gcd_sin.sv
module gcd_sin (
    input  logic           i_clk,
    input  logic           i_en,
    input  gcd_pkg::t_q    i_x,
    input  gcd_pkg::t_side i_side,
    output gcd_pkg::t_q    o_sin,
    output gcd_pkg::t_q    o_x,
    output gcd_pkg::t_side o_side
);
    import gcd_pkg::*;

    t_pp   r_sq_pp;
    t_q    r_sq_x;
    t_side r_sq_side;
    t_q    r_x2;
    t_q    r_x1;
    t_side r_side1;
    t_pp   r_fin_pp;
    t_q    r_fin_x;
    t_side r_fin_side;
    t_q    r_sin;
    t_q    r_out_x;
    t_side r_out_side;

    t_q    w_br   [SIN_TERMS+1];
    t_q    w_x    [SIN_TERMS+1];
    t_q    w_x2   [SIN_TERMS+1];
    t_side w_side [SIN_TERMS+1];

    // square the angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_pp   <= mul_pp(i_x, i_x);
            r_sq_x    <= i_x;
            r_sq_side <= i_side;
            r_x2      <= mulq_of(r_sq_pp);
            r_x1      <= r_sq_x;
            r_side1   <= r_sq_side;
        end
    end

    assign w_br[0]   = Q_ONE;
    assign w_x[0]    = r_x1;
    assign w_x2[0]   = r_x2;
    assign w_side[0] = r_side1;

    // Horner bracket, highest term first
    for (genvar g = 0; g < SIN_TERMS; g++) begin : g_term
        localparam int          KC       = SIN_TERMS - g;
        localparam t_den        DEN      = t_den'(2 * KC * (2 * KC + 1));
        localparam logic [64:0] REC_FULL = (65'd1 << 64) / 65'(DEN);
        localparam t_q          REC      = REC_FULL[63:0];

        t_pp   r_a_pp;
        t_q    r_a_x, r_a_x2;
        t_side r_a_s;
        t_q    r_b_m, r_b_x, r_b_x2;
        t_side r_b_s;
        t_pp   r_c_pp;
        t_q    r_c_m, r_c_x, r_c_x2;
        t_side r_c_s;
        t_q    r_d_q0, r_d_m, r_d_x, r_d_x2;
        t_side r_d_s;
        t_q    r_e_qd, r_e_q0, r_e_m, r_e_x, r_e_x2;
        t_side r_e_s;
        t_q    r_f_br, r_f_x, r_f_x2;
        t_side r_f_s;
        t_q    w_rem;
        t_q    w_q;

        // quotient estimate is low by at most one
        always_comb begin
            w_rem = r_e_m - r_e_qd;
            w_q   = (w_rem >= 64'(DEN)) ? r_e_q0 + 64'd1 : r_e_q0;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_a_pp <= mul_pp(w_x2[g], w_br[g]);
                r_a_x  <= w_x[g];
                r_a_x2 <= w_x2[g];
                r_a_s  <= w_side[g];

                r_b_m  <= mulq_of(r_a_pp);
                r_b_x  <= r_a_x;
                r_b_x2 <= r_a_x2;
                r_b_s  <= r_a_s;

                r_c_pp <= mul_pp(r_b_m, REC);
                r_c_m  <= r_b_m;
                r_c_x  <= r_b_x;
                r_c_x2 <= r_b_x2;
                r_c_s  <= r_b_s;

                r_d_q0 <= mulhi_of(r_c_pp);
                r_d_m  <= r_c_m;
                r_d_x  <= r_c_x;
                r_d_x2 <= r_c_x2;
                r_d_s  <= r_c_s;

                r_e_qd <= r_d_q0 * 64'(DEN);
                r_e_q0 <= r_d_q0;
                r_e_m  <= r_d_m;
                r_e_x  <= r_d_x;
                r_e_x2 <= r_d_x2;
                r_e_s  <= r_d_s;

                r_f_br <= (w_q >= Q_ONE) ? '0 : Q_ONE - w_q;
                r_f_x  <= r_e_x;
                r_f_x2 <= r_e_x2;
                r_f_s  <= r_e_s;
            end
        end

        assign w_br[g+1]   = r_f_br;
        assign w_x[g+1]    = r_f_x;
        assign w_x2[g+1]   = r_f_x2;
        assign w_side[g+1] = r_f_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fin_pp   <= mul_pp(w_x[SIN_TERMS], w_br[SIN_TERMS]);
            r_fin_x    <= w_x[SIN_TERMS];
            r_fin_side <= w_side[SIN_TERMS];
            r_sin      <= mulq_of(r_fin_pp);
            r_out_x    <= r_fin_x;
            r_out_side <= r_fin_side;
        end
    end

    assign o_sin  = r_sin;
    assign o_x    = r_out_x;
    assign o_side = r_out_side;

endmodule

### design/gcd_sqrt.sv
module gcd_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  gcd_pkg::t_q i_h,
    output gcd_pkg::t_q o_root
);
    import gcd_pkg::*;

    t_q w_r [SQRT_STEPS+1];
    t_q w_h [SQRT_STEPS+1];

    assign w_r[0] = '0;
    assign w_h[0] = i_h;

    // one result bit per two stages, top bit first
    for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
        localparam t_q BIT = t_q'(1) << (SQRT_STEPS - 1 - g);

        t_pp r_pp;
        t_q  r_c, r_r, r_h;
        t_q  r_rn, r_hn;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pp <= mul_pp(w_r[g] | BIT, w_r[g] | BIT);
                r_c  <= w_r[g] | BIT;
                r_r  <= w_r[g];
                r_h  <= w_h[g];
                r_rn <= (mulq_of(r_pp) <= r_h) ? r_c : r_r;
                r_hn <= r_h;
            end
        end

        assign w_r[g+1] = r_rn;
        assign w_h[g+1] = r_hn;
    end

    assign o_root = w_r[SQRT_STEPS];

endmodule

### design/gcd_asin.sv
module gcd_asin (
    input  logic        i_clk,
    input  logic        i_en,
    input  gcd_pkg::t_q i_s,
    input  logic        i_swap,
    output gcd_pkg::t_q o_t,
    output logic        o_swap
);
    import gcd_pkg::*;

    t_q    w_t    [ASIN_STEPS+1];
    t_side w_side [ASIN_STEPS+1];
    t_q    r_t;
    logic  r_swap;

    assign w_t[0]    = '0;
    assign w_side[0] = '{swap: i_swap, s: i_s};

    // bisection on the sine, top bit first
    for (genvar g = 0; g < ASIN_STEPS; g++) begin : g_step
        localparam t_q BIT = t_q'(1) << (ASIN_STEPS - 1 - g);

        t_q    r_c;
        t_side r_side;
        t_q    w_sin;
        t_q    w_x;
        t_side w_os;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_c    <= w_t[g] | BIT;
                r_side <= w_side[g];
            end
        end

        gcd_sin u_sin (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_x    (r_c),
            .i_side (r_side),
            .o_sin  (w_sin),
            .o_x    (w_x),
            .o_side (w_os)
        );

        // keep the bit if the sine does not overshoot
        assign w_t[g+1]    = (w_sin <= w_os.s) ? w_x : (w_x & ~BIT);
        assign w_side[g+1] = w_os;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= w_t[ASIN_STEPS];
            r_swap <= w_side[ASIN_STEPS].swap;
        end
    end

    assign o_t    = r_t;
    assign o_swap = r_swap;

endmodule

### design/great_circle_distance.sv
// Haversine distance of two points on a 6371 km sphere, in whole meters.
// Each request carries two latitude/longitude pairs in signed micro-degrees;
// out-of-range coordinates saturate to +/-90 and +/-180 degrees. The block
// is a fixed pipeline of 4833 register stages: one request is taken every
// clock while it is not frozen, and results leave in request order.
// Nearly all of that depth is the arcsine, a 60-step bisection where every
// step runs a full 12-term sine series (77 stages per step); the two square
// roots take 122 stages and each sine 76. The whole pipeline advances as
// one: it freezes only while a finished result sits at the output and the
// downstream side stalls, and then o_stall is raised to the upstream side.
// All math is Q60 unsigned fixed point; 64x64 products are split into four
// 32x32 partial products and summed in the following stage.
module great_circle_distance (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [27:0]  i_lat_a,
    input  logic signed [28:0]  i_lon_a,
    input  logic signed [27:0]  i_lat_b,
    input  logic signed [28:0]  i_lon_b,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [24:0]         o_distance_m
);
    import gcd_pkg::*;

    localparam int TOP_LAT = 3 + SIN_LAT + 6 + SQRT_LAT + 1 + ASIN_LAT + 4;
    localparam int ARG_IDX = 3 + SIN_LAT + 6 + SQRT_LAT;
    localparam t_q ARG_MAX = 64'h0C00_0000_0000_0000;

    function automatic t_lat clamp_lat(input t_lat v);
        if (v > LAT_LIM) return LAT_LIM;
        if (v < -LAT_LIM) return -LAT_LIM;
        return v;
    endfunction

    function automatic t_lon clamp_lon(input t_lon v);
        if (v > LON_LIM) return LON_LIM;
        if (v < -LON_LIM) return -LON_LIM;
        return v;
    endfunction

    logic [TOP_LAT-1:0] r_v;
    logic               w_adv;

    // input stage: saturated coordinates
    t_lat r_la, r_lb;
    t_lon r_oa, r_ob;

    // angle stage: gaps and complements in half micro-degree units
    logic signed [28:0] w_dlat_s;
    logic signed [29:0] w_dlon_s;
    logic [28:0]        w_dlat_abs;
    logic [29:0]        w_dlon_abs;
    logic [28:0]        w_dlon_fold;
    t_unit              w_la_abs, w_lb_abs;
    t_unit              r_n_dlat, r_n_dlon, r_n_ca, r_n_cb;

    // radians
    t_q r_x_dlat, r_x_dlon, r_x_ca, r_x_cb;

    // sines
    t_q    w_u, w_v, w_ca, w_cb;
    t_q    w_unused_x [4];
    t_side w_unused_s [4];

    // haversine sum
    t_pp r_p_uu, r_p_cc, r_p_vv, r_p_w;
    t_q  r_uu, r_cc, r_vv, r_uu2, r_uu3, r_w;
    t_q  w_hsum;
    t_q  r_h, r_h2, r_omh;

    // roots and arcsine
    t_q   w_s, w_c;
    t_q   r_arg;
    logic r_swap;
    t_q   w_t;
    logic w_swap;

    // distance
    t_q          r_theta;
    t_pp         r_p_d;
    t_q          r_twice;
    t_q          w_round;
    logic [24:0] r_dist;

    // advance everything unless the output holds a result being stalled
    assign w_adv   = !(r_v[TOP_LAT-1] && i_stall);
    assign o_stall = r_v[TOP_LAT-1] & i_stall;
    assign o_valid = r_v[TOP_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[TOP_LAT-2:0], i_valid};
        end
    end

    always_comb begin
        w_dlat_s    = 29'(r_la) - 29'(r_lb);
        w_dlon_s    = 30'(r_oa) - 30'(r_ob);
        w_dlat_abs  = w_dlat_s[28] ? 29'(-w_dlat_s) : 29'(w_dlat_s);
        w_dlon_abs  = w_dlon_s[29] ? 30'(-w_dlon_s) : 30'(w_dlon_s);
        // a gap past half a turn folds back onto the short way round
        w_dlon_fold = (w_dlon_abs[28:0] > QUARTER_UNITS) ? HALF_UNITS - w_dlon_abs[28:0]
                                                         : w_dlon_abs[28:0];
        w_la_abs    = r_la[27] ? t_unit'(-r_la) : t_unit'(r_la);
        w_lb_abs    = r_lb[27] ? t_unit'(-r_lb) : t_unit'(r_lb);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_la <= clamp_lat(i_lat_a);
            r_oa <= clamp_lon(i_lon_a);
            r_lb <= clamp_lat(i_lat_b);
            r_ob <= clamp_lon(i_lon_b);

            r_n_dlat <= w_dlat_abs[27:0];
            r_n_dlon <= w_dlon_fold[27:0];
            // cosine of a latitude is the sine of its complement
            r_n_ca   <= (t_unit'(LAT_LIM) - w_la_abs) << 1;
            r_n_cb   <= (t_unit'(LAT_LIM) - w_lb_abs) << 1;

            r_x_dlat <= t_q'(r_n_dlat) * RAD_PER_UNIT;
            r_x_dlon <= t_q'(r_n_dlon) * RAD_PER_UNIT;
            r_x_ca   <= t_q'(r_n_ca) * RAD_PER_UNIT;
            r_x_cb   <= t_q'(r_n_cb) * RAD_PER_UNIT;
        end
    end

    gcd_sin u_sin_dlat (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_x_dlat), .i_side ('0),
        .o_sin (w_u), .o_x (w_unused_x[0]), .o_side (w_unused_s[0])
    );

    gcd_sin u_sin_dlon (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_x_dlon), .i_side ('0),
        .o_sin (w_v), .o_x (w_unused_x[1]), .o_side (w_unused_s[1])
    );

    gcd_sin u_cos_a (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_x_ca), .i_side ('0),
        .o_sin (w_ca), .o_x (w_unused_x[2]), .o_side (w_unused_s[2])
    );

    gcd_sin u_cos_b (
        .i_clk (i_clk), .i_en (w_adv), .i_x (r_x_cb), .i_side ('0),
        .o_sin (w_cb), .o_x (w_unused_x[3]), .o_side (w_unused_s[3])
    );

    assign w_hsum = r_uu3 + r_w;

    // h = u^2 + ca*cb*v^2, clamped to one
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_p_uu <= mul_pp(w_u, w_u);
            r_p_cc <= mul_pp(w_ca, w_cb);
            r_p_vv <= mul_pp(w_v, w_v);

            r_uu   <= mulq_of(r_p_uu);
            r_cc   <= mulq_of(r_p_cc);
            r_vv   <= mulq_of(r_p_vv);

            r_p_w  <= mul_pp(r_cc, r_vv);
            r_uu2  <= r_uu;

            r_w    <= mulq_of(r_p_w);
            r_uu3  <= r_uu2;

            r_h    <= (w_hsum > Q_ONE) ? Q_ONE : w_hsum;

            r_h2   <= r_h;
            r_omh  <= Q_ONE - r_h;
        end
    end

    gcd_sqrt u_sqrt_h (
        .i_clk (i_clk), .i_en (w_adv), .i_h (r_h2), .o_root (w_s)
    );

    gcd_sqrt u_sqrt_omh (
        .i_clk (i_clk), .i_en (w_adv), .i_h (r_omh), .o_root (w_c)
    );

    // run the arcsine on the smaller of the two roots
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_arg  <= (w_s <= w_c) ? w_s : w_c;
            r_swap <= !(w_s <= w_c);
        end
    end

    gcd_asin u_asin (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_s    (r_arg),
        .i_swap (r_swap),
        .o_t    (w_t),
        .o_swap (w_swap)
    );

    assign w_round = r_twice + 64'd1;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (w_swap) begin
                r_theta <= (w_t >= HALF_PI) ? '0 : HALF_PI - w_t;
            end else begin
                r_theta <= w_t;
            end
            r_p_d   <= mul_pp(r_theta, TWO_DIAM_M);
            r_twice <= mulq_of(r_p_d);
            r_dist  <= w_round[25:1];
        end
    end

    assign o_distance_m = r_dist;

    a_stall_only_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("upstream stalled with no result at the output");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted request did not enter the pipeline");

    a_freeze_keeps_valids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_v))
        else $error("pipeline valids moved while frozen");

    a_asin_arg_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[ARG_IDX] |-> (r_arg <= ARG_MAX))
        else $error("arcsine argument above 0.75");

endmodule
